FILE: hw/rtl/scb_pkg.sv
// ----------------------------------------------------------------------------
// scb_pkg
// Shared types and constants for the segment corridor blocker finder.
// ----------------------------------------------------------------------------
package scb_pkg;

  localparam int RAD_W    = 23;
  localparam int CNT_CFG_W = 6;
  localparam int IDX_O_W  = 5;
  localparam int MASK_W   = 32;
  localparam int SLOT_W   = 5;
  localparam int T_FRAC   = 16;
  localparam int T_W      = T_FRAC + 1;
  localparam int SQ_W     = 64;
  localparam int SQ_STEPS = 32;
  localparam int ROOT_W   = 32;
  localparam int PEN_W    = 34;
  localparam int CNT_CMP_W = 9;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic CFG_OBSTACLE_COUNT = 1'b0;
  localparam logic CFG_ROUTE_MARGIN   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN,
    ST_LSUM,
    ST_RD,
    ST_DIFF,
    ST_DOT,
    ST_DSUM,
    ST_DIV,
    ST_SCALE,
    ST_ERR,
    ST_SQ,
    ST_D2,
    ST_SQRT,
    ST_PEN,
    ST_DONE
  } scb_state_t;

endpackage

FILE: hw/rtl/segment_corridor_blocker_finder.sv
// ----------------------------------------------------------------------------
// segment_corridor_blocker_finder
// Circle obstacle table with a segment query for the primary blocker.
// ----------------------------------------------------------------------------
// Load items (tuser 0) write one obstacle slot. A query item (tuser 1)
// walks slots 0 to count-1, count capped at MAX_OBSTACLES, one at a time
// through a single datapath: per slot the 16-step divide runs unless the
// projection clamps, then the square root wait (32 steps plus start and
// done). A query sets up in LEN and LSUM and hands off the result in DONE,
// which waits until the output register is free. The table sits in one
// synchronous memory read one slot per cycle; no clearing pass is needed.
// A new item is taken while the last result waits at the output register.
module segment_corridor_blocker_finder
  import scb_pkg::*;
#(
  parameter int MAX_OBSTACLES = 32,
  parameter int COORD_BITS    = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // slot, obj_x, obj_y, obj_radius, start_x, start_y, goal_x, goal_y
  input  logic [((SLOT_W + RAD_W + 6 * COORD_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // op
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // blocker_index, blocker_x, blocker_y, blocker_radius, blocking_mask
  output logic [((IDX_O_W + 2 * COORD_BITS + RAD_W + MASK_W + 7) / 8) * 8 - 1:0] out_tdata,
  // blocked
  output logic                out_tuser,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [RAD_W-1:0]    cfg_wdata
);

  localparam int OUT_RAW = IDX_O_W + 2 * COORD_BITS + RAD_W + MASK_W;
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
  localparam int CW      = (COORD_BITS > 30) ? 30 : COORD_BITS;
  localparam int DW      = CW + 1;
  localparam int PW      = 2 * DW + 1;
  localparam int EW      = CW + 3;
  localparam int AW      = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int NW      = $clog2(MAX_OBSTACLES + 1);
  localparam int MW      = 2 * CW + RAD_W;
  localparam int DCW     = $clog2(T_FRAC);

  localparam int F_X  = SLOT_W;
  localparam int F_Y  = F_X + COORD_BITS;
  localparam int F_R  = F_Y + COORD_BITS;
  localparam int F_SX = F_R + RAD_W;
  localparam int F_SY = F_SX + COORD_BITS;
  localparam int F_GX = F_SY + COORD_BITS;
  localparam int F_GY = F_GX + COORD_BITS;

  scb_state_t state_r, state_nxt;

  logic [CNT_CFG_W-1:0] count_r;
  logic [RAD_W-1:0]     margin_r;

  logic [MW-1:0] mem [MAX_OBSTACLES];
  logic [MW-1:0] mem_q_r;
  logic [NW-1:0] idx_r, n_val;

  logic signed [CW-1:0]   in_ox, in_oy, in_sx, in_sy, in_gx, in_gy;
  logic signed [CW-1:0]   sx_r, sy_r, cx_r, cy_r;
  logic [RAD_W-1:0]       cr_r;
  logic signed [DW-1:0]   ax_r, ay_r, dx_r, dy_r;
  logic [DW-1:0]          absx_r, absy_r;
  logic signed [2*DW-1:0] lx_r, ly_r, px_r, py_r;
  logic signed [PW-1:0]   len2_r, dot;
  logic [PW:0]            rem_r, rem2;
  logic [DCW-1:0]         dcnt_r;
  logic [T_W-1:0]         t_r;
  logic [DW+16:0]         prodx, prody;
  logic [DW:0]            qx_r, qy_r;
  logic signed [EW-1:0]   ex_r, ey_r;
  logic signed [2*EW-1:0] ex2_r, ey2_r;
  logic [SQ_W-1:0]        d2_r;
  logic                   sq_start_r, sq_done;
  logic [ROOT_W-1:0]      root;
  logic signed [PEN_W-1:0] pen, top_pen_r;
  logic                   hit, better;

  logic                   blocked_r;
  logic [T_W-1:0]         best_t_r;
  logic [AW-1:0]          best_i_r;
  logic signed [CW-1:0]   best_x_r, best_y_r;
  logic [RAD_W-1:0]       best_r_r;
  logic [MASK_W-1:0]      mask_r;

  logic                   out_tvalid_r, out_tuser_r;
  logic [OUT_W-1:0]       out_tdata_r;
  logic                   in_acc, out_free;

  assign in_ox = CW'(in_tdata[F_X +: COORD_BITS]);
  assign in_oy = CW'(in_tdata[F_Y +: COORD_BITS]);
  assign in_sx = CW'(in_tdata[F_SX +: COORD_BITS]);
  assign in_sy = CW'(in_tdata[F_SY +: COORD_BITS]);
  assign in_gx = CW'(in_tdata[F_GX +: COORD_BITS]);
  assign in_gy = CW'(in_tdata[F_GY +: COORD_BITS]);

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign n_val = ({3'b0, count_r} > CNT_CMP_W'(MAX_OBSTACLES)) ?
                 NW'(MAX_OBSTACLES) : NW'(count_r);

  assign dot   = PW'(px_r) + PW'(py_r);
  assign rem2  = rem_r << 1;
  assign prodx = (DW+17)'(absx_r) * (DW+17)'(t_r);
  assign prody = (DW+17)'(absy_r) * (DW+17)'(t_r);
  assign pen   = PEN_W'(cr_r) + PEN_W'(margin_r) - PEN_W'(root);
  assign hit   = !pen[PEN_W-1] && (pen != '0);
  assign better = !blocked_r || (t_r < best_t_r) ||
                  ((t_r == best_t_r) && (pen > top_pen_r));

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && in_tuser == OP_QUERY) state_nxt = ST_LEN;
      end
      ST_LEN:   state_nxt = ST_LSUM;
      ST_LSUM:  state_nxt = (n_val == '0) ? ST_DONE : ST_RD;
      ST_RD:    state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_DOT;
      ST_DOT:   state_nxt = ST_DSUM;
      ST_DSUM: begin
        if (len2_r == '0 || dot[PW-1] || dot == '0 || dot >= len2_r) begin
          state_nxt = ST_SCALE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV:   if (dcnt_r == DCW'(T_FRAC - 1)) state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_ERR;
      ST_ERR:   state_nxt = ST_SQ;
      ST_SQ:    state_nxt = ST_D2;
      ST_D2:    state_nxt = ST_SQRT;
      ST_SQRT:  if (sq_done) state_nxt = ST_PEN;
      ST_PEN:   state_nxt = (idx_r + 1'b1 == n_val) ? ST_DONE : ST_RD;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      margin_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_OBSTACLE_COUNT) count_r <= CNT_CFG_W'(cfg_wdata);
      if (cfg_index == CFG_ROUTE_MARGIN)   margin_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == OP_LOAD &&
        {4'b0, in_tdata[SLOT_W-1:0]} < CNT_CMP_W'(MAX_OBSTACLES)) begin
      mem[AW'(in_tdata[SLOT_W-1:0])] <= {in_tdata[F_R +: RAD_W], in_oy, in_ox};
    end
    mem_q_r <= mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_start_r <= 1'b0;
      blocked_r  <= 1'b0;
      idx_r      <= '0;
    end else begin
      sq_start_r <= (state_r == ST_D2);
      case (state_r)
        ST_IDLE: begin
          if (in_acc && in_tuser == OP_QUERY) begin
            sx_r      <= in_sx;
            sy_r      <= in_sy;
            ax_r      <= DW'(in_gx) - DW'(in_sx);
            ay_r      <= DW'(in_gy) - DW'(in_sy);
            blocked_r <= 1'b0;
            mask_r    <= '0;
            idx_r     <= '0;
          end
        end
        ST_LEN: begin
          lx_r   <= ax_r * ax_r;
          ly_r   <= ay_r * ay_r;
          absx_r <= ax_r[DW-1] ? DW'(-ax_r) : DW'(ax_r);
          absy_r <= ay_r[DW-1] ? DW'(-ay_r) : DW'(ay_r);
        end
        ST_LSUM: len2_r <= PW'(lx_r) + PW'(ly_r);
        ST_DIFF: begin
          cx_r <= mem_q_r[CW-1:0];
          cy_r <= mem_q_r[2*CW-1:CW];
          cr_r <= mem_q_r[MW-1:2*CW];
          dx_r <= DW'($signed(mem_q_r[CW-1:0])) - DW'(sx_r);
          dy_r <= DW'($signed(mem_q_r[2*CW-1:CW])) - DW'(sy_r);
        end
        ST_DOT: begin
          px_r <= dx_r * ax_r;
          py_r <= dy_r * ay_r;
        end
        ST_DSUM: begin
          rem_r  <= (PW+1)'(dot);
          dcnt_r <= '0;
          if (len2_r == '0 || dot[PW-1] || dot == '0) begin
            t_r <= '0;
          end else if (dot >= len2_r) begin
            t_r <= T_W'(1) << T_FRAC;
          end else begin
            t_r <= '0;
          end
        end
        ST_DIV: begin
          dcnt_r <= dcnt_r + 1'b1;
          if (rem2 >= {1'b0, len2_r}) begin
            rem_r <= rem2 - {1'b0, len2_r};
            t_r   <= {t_r[T_W-2:0], 1'b1};
          end else begin
            rem_r <= rem2;
            t_r   <= {t_r[T_W-2:0], 1'b0};
          end
        end
        ST_SCALE: begin
          qx_r <= (DW+1)'((prodx + (DW+17)'(32768)) >> T_FRAC);
          qy_r <= (DW+1)'((prody + (DW+17)'(32768)) >> T_FRAC);
        end
        ST_ERR: begin
          ex_r <= EW'(cx_r) - EW'(sx_r) - (ax_r[DW-1] ? -EW'(qx_r) : EW'(qx_r));
          ey_r <= EW'(cy_r) - EW'(sy_r) - (ay_r[DW-1] ? -EW'(qy_r) : EW'(qy_r));
        end
        ST_SQ: begin
          ex2_r <= ex_r * ex_r;
          ey2_r <= ey_r * ey_r;
        end
        ST_D2: begin
          d2_r <= SQ_W'(ex2_r + ey2_r);
        end
        ST_PEN: begin
          idx_r <= idx_r + 1'b1;
          if (hit) begin
            blocked_r <= 1'b1;
            if (32'(idx_r) < 32'(MASK_W)) begin
              mask_r <= mask_r | (MASK_W'(1) << idx_r);
            end
            if (better) begin
              best_t_r   <= t_r;
              top_pen_r  <= pen;
              best_i_r   <= idx_r[AW-1:0];
              best_x_r   <= cx_r;
              best_y_r   <= cy_r;
              best_r_r   <= cr_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  scb_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start_r),
    .x     (d2_r),
    .done  (sq_done),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      if (state_r == ST_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
        out_tuser_r  <= blocked_r;
        if (blocked_r) begin
          out_tdata_r <= OUT_W'({mask_r, best_r_r, COORD_BITS'(best_y_r),
                                 COORD_BITS'(best_x_r), IDX_O_W'(best_i_r)});
        end else begin
          out_tdata_r <= '0;
        end
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

  a_clear_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_tuser_r |-> out_tdata_r == '0)
    else $error("unblocked result carries data");

  a_sqrt_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> state_r == ST_SQRT)
    else $error("square root finished outside its wait");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PEN |-> idx_r < n_val)
    else $error("slot index past count");

endmodule

FILE: hw/rtl/scb_isqrt.sv
// ----------------------------------------------------------------------------
// scb_isqrt
// Bitwise integer square root, one step per cycle, floor result.
// ----------------------------------------------------------------------------
module scb_isqrt
  import scb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SQ_W-1:0]   x,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CW = $clog2(SQ_STEPS);

  logic [SQ_W-1:0] x_r, res_r, bit_r;
  logic [SQ_W-1:0] x_nxt, res_nxt, trial;
  logic [CW-1:0]   cnt_r;
  logic            busy_r, done_r;

  always_comb begin
    trial = res_r + bit_r;
    if (x_r >= trial) begin
      x_nxt   = x_r - trial;
      res_nxt = (res_r >> 1) + bit_r;
    end else begin
      x_nxt   = x_r;
      res_nxt = res_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CW'(SQ_STEPS - 1));
      if (start) begin
        x_r    <= x;
        res_r  <= '0;
        bit_r  <= SQ_W'(1) << (SQ_W - 2);
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        x_r   <= x_nxt;
        res_r <= res_nxt;
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(SQ_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[ROOT_W-1:0];

endmodule
